// ===== rtl/ita_pkg.sv =====
// shared constants, types and helpers for the integer to ascii formatter
package ita_pkg;

  localparam int VALUE_W = 32;
  localparam int MODE_W  = 2;
  localparam int CHAR_W  = 7;
  localparam int DIGIT_W = 4;
  // ten decimal digits cover any 32-bit magnitude, hex needs eight
  localparam int DIGITS  = 10;
  localparam int CNT_W   = $clog2(VALUE_W);
  localparam int REM_W   = $clog2(DIGITS + 1);

  localparam logic [MODE_W-1:0] MODE_SDEC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UDEC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HEX  = 2'd2;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_A     = 7'h61;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2d;

  typedef logic [DIGIT_W-1:0] digit_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_DABBLE,
    CELL_MOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     hex;
  } cell_ctl_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(digit_t d);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < 4'd10) return ASCII_ZERO + ext;
    else return ASCII_A + ext - 7'd10;
  endfunction

endpackage

// ===== rtl/ita_ifs.sv =====
// valid/ready channel interfaces for the formatter input and character output
interface ita_in_if;
  import ita_pkg::*;
  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  value;
  logic [MODE_W-1:0]   mode;
  modport source (output valid, output value, output mode, input ready);
  modport sink   (input valid, input value, input mode, output ready);
endinterface

interface ita_out_if;
  import ita_pkg::*;
  logic               valid;
  logic               ready;
  logic [CHAR_W-1:0]  character;
  logic               last;
  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== rtl/ita_digit_cell.sv =====
// one digit cell of the shift-and-add-3 conversion chain
module ita_digit_cell
  import ita_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      bit_in,
  input  digit_t    digit_in,
  output logic      bit_out,
  output digit_t    digit_out
);

  digit_t digit_r;
  digit_t digit_nxt;
  digit_t adj;

  // decimal digits of five or more get 3 added before the shift
  always_comb begin
    if (!ctl.hex && digit_r >= 4'd5) adj = digit_r + 4'd3;
    else adj = digit_r;
  end

  assign bit_out   = adj[DIGIT_W-1];
  assign digit_out = digit_r;

  always_comb begin
    unique case (ctl.op)
      CELL_HOLD:   digit_nxt = digit_r;
      CELL_CLEAR:  digit_nxt = '0;
      CELL_DABBLE: digit_nxt = {adj[DIGIT_W-2:0], bit_in};
      CELL_MOVE:   digit_nxt = digit_in;
      default:     digit_nxt = digit_r;
    endcase
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

// ===== rtl/integer_to_ascii_formatter.sv =====
// integer to ascii formatter: serial binary to bcd/hex conversion and digit emitter
// flow: an input beat is captured in idle, then the conversion, zero skipping and emission states follow
// during conversion one magnitude bit enters the digit chain per cycle
// leading zero digits are skipped one per cycle; then one character per output beat
// one number in flight: next input beat taken after the last character beat
// rst_n is synchronous active low and returns the controller to idle
module integer_to_ascii_formatter
  import ita_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ita_in_if.sink    in_ch,
  ita_out_if.source out_ch
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [REM_W-1:0]   rem_r;
  logic [VALUE_W-1:0] mag_r;
  logic               neg_r;
  logic               hex_r;

  cell_ctl_t          ctl;
  digit_t             digits [DIGITS];
  logic [DIGITS-2:0]  carry;
  digit_t             top;
  logic               in_acc;
  logic               out_acc;

  assign top     = digits[DIGITS-1];
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign out_ch.valid     = (state_r == ST_EMIT);
  assign out_ch.character = neg_r ? ASCII_MINUS : digit_to_ascii(top);
  assign out_ch.last      = !neg_r && (rem_r == REM_W'(1));

  always_comb begin
    ctl.hex = hex_r;
    ctl.op  = CELL_HOLD;
    unique case (state_r)
      ST_IDLE: if (in_acc) ctl.op = CELL_CLEAR;
      ST_CONV: ctl.op = CELL_DABBLE;
      ST_SKIP: if (top == '0 && rem_r > REM_W'(1)) ctl.op = CELL_MOVE;
      ST_EMIT: if (out_acc && !neg_r && rem_r != REM_W'(1)) ctl.op = CELL_MOVE;
      default: ctl.op = CELL_HOLD;
    endcase
  end

  // cell 0 takes the magnitude msb first; digits move toward the top cell
  for (genvar i = 0; i < DIGITS; i++) begin : g_cell
    if (i == 0) begin : g_first
      ita_digit_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .bit_in    (mag_r[VALUE_W-1]),
        .digit_in  (digit_t'(0)),
        .bit_out   (carry[0]),
        .digit_out (digits[0])
      );
    end else if (i == DIGITS - 1) begin : g_last
      ita_digit_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .bit_in    (carry[i-1]),
        .digit_in  (digits[i-1]),
        .bit_out   (),
        .digit_out (digits[i])
      );
    end else begin : g_mid
      ita_digit_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .bit_in    (carry[i-1]),
        .digit_in  (digits[i-1]),
        .bit_out   (carry[i]),
        .digit_out (digits[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      rem_r   <= '0;
      neg_r   <= 1'b0;
      hex_r   <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            // only mode bit 1 picks the base
            hex_r <= in_ch.mode[1];
            neg_r <= (in_ch.mode == MODE_SDEC) && in_ch.value[VALUE_W-1];
            if (in_ch.mode == MODE_SDEC && in_ch.value[VALUE_W-1]) begin
              mag_r <= ~in_ch.value + VALUE_W'(1);
            end else begin
              mag_r <= in_ch.value;
            end
            cnt_r   <= '0;
            state_r <= ST_CONV;
          end
        end
        ST_CONV: begin
          mag_r <= {mag_r[VALUE_W-2:0], 1'b0};
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(VALUE_W - 1)) begin
            rem_r   <= REM_W'(DIGITS);
            state_r <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          if (top == '0 && rem_r > REM_W'(1)) rem_r <= rem_r - REM_W'(1);
          else state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_acc) begin
            priority if (neg_r) neg_r <= 1'b0;
            else if (rem_r == REM_W'(1)) state_r <= ST_IDLE;
            else rem_r <= rem_r - REM_W'(1);
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/ita_checker.sv =====
// port-level assertions for the integer to ascii formatter, bound to the top level
module ita_checker
  import ita_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] character,
  input logic              last
);

  // a stalled character beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(character) && $stable(last))
    else $error("stalled output beat changed");

  // the conversion states come before any character, so no character right after an input beat
  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("character valid right after input beat");

  // the final character closes the number
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && last |=> !out_valid && in_ready)
    else $error("output continued after last character");

  // a minus sign is never the final character
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && character == ASCII_MINUS |-> !last)
    else $error("minus sign flagged as last");

  // no new number taken while characters are pending
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while characters pending");

endmodule

bind integer_to_ascii_formatter ita_checker u_ita_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .character (out_ch.character),
  .last      (out_ch.last)
);
